@@ rtl/ffpa_pkg.sv @@
// Package for the first-fit partition allocator: widths, status codes,
// controller states and the command/status structs. No dependencies.
package ffpa_pkg;

    localparam int MaxSegments = 16;
    localparam int AddrBits    = 16;
    localparam int IdBits      = 8;
    localparam int IdxBits     = $clog2(MaxSegments);
    localparam int CntBits     = $clog2(MaxSegments + 1);
    localparam logic [15:0] TotalSizeReset = 16'd1024;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EXISTS   = 3'd1,
        ST_NOFIT    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_FIT,
        S_DECIDE,
        S_SHIFT_UP,
        S_SPLIT,
        S_FREE,
        S_SHIFT_DN,
        S_RESULT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic  load_req;   // capture the request
        logic  scan_clr;   // reset scan index to 0
        logic  scan_step;  // advance scan index
        logic  mark_hit;   // remember the scan index as the found entry
        logic  take_whole; // exact fit: mark owned
        logic  open_gap;   // prepare shift-up from the top
        logic  shift_up;   // one copy step upward
        logic  split;      // write owned part and free remainder
        logic  merge_free; // perform merge decision on free
        logic  shift_dn;   // one copy step downward
        logic  set_result;
        status_t result;
    } ffpa_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_free_req;
        logic scan_end;    // index reached seg_count
        logic owner_hit;   // current entry is owned by the request id
        logic fit_hit;     // current entry is free and long enough
        logic exact;       // found segment length equals request
        logic size_zero;
        logic table_full;
        logic up_done;     // shift-up reached the found entry
        logic dn_done;
    } ffpa_stat_t;

endpackage

@@ rtl/ffpa_ctrl.sv @@
// Controller state machine of the first-fit partition allocator.
// Depends on ffpa_pkg.
module ffpa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic                out_busy,
    input  ffpa_pkg::ffpa_stat_t stat,
    output ffpa_pkg::ffpa_cmd_t  cmd,
    output logic                idle,
    output logic                res_valid
);

    ffpa_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffpa_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.result = ffpa_pkg::ST_OK;
        idle = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            ffpa_pkg::S_IDLE: begin
                idle = 1'b1;
                if (in_fire) begin
                    cmd.load_req = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next = ffpa_pkg::S_FIND;
                end
            end
            ffpa_pkg::S_FIND: begin
                if (stat.scan_end) begin
                    if (stat.is_free_req) begin
                        cmd.set_result = 1'b1;
                        cmd.result = ffpa_pkg::ST_NOTFOUND;
                        state_next = ffpa_pkg::S_RESULT;
                    end else if (stat.size_zero) begin
                        cmd.set_result = 1'b1;
                        cmd.result = ffpa_pkg::ST_NOFIT;
                        state_next = ffpa_pkg::S_RESULT;
                    end else begin
                        cmd.scan_clr = 1'b1;
                        state_next = ffpa_pkg::S_FIT;
                    end
                end else if (stat.owner_hit) begin
                    if (stat.is_free_req) begin
                        cmd.mark_hit = 1'b1;
                        state_next = ffpa_pkg::S_FREE;
                    end else begin
                        cmd.set_result = 1'b1;
                        cmd.result = ffpa_pkg::ST_EXISTS;
                        state_next = ffpa_pkg::S_RESULT;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ffpa_pkg::S_FIT: begin
                if (stat.scan_end) begin
                    cmd.set_result = 1'b1;
                    cmd.result = ffpa_pkg::ST_NOFIT;
                    state_next = ffpa_pkg::S_RESULT;
                end else if (stat.fit_hit) begin
                    cmd.mark_hit = 1'b1;
                    state_next = ffpa_pkg::S_DECIDE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ffpa_pkg::S_DECIDE: begin
                if (stat.exact) begin
                    cmd.take_whole = 1'b1;
                    cmd.set_result = 1'b1;
                    cmd.result = ffpa_pkg::ST_OK;
                    state_next = ffpa_pkg::S_RESULT;
                end else if (stat.table_full) begin
                    cmd.set_result = 1'b1;
                    cmd.result = ffpa_pkg::ST_FULL;
                    state_next = ffpa_pkg::S_RESULT;
                end else begin
                    cmd.open_gap = 1'b1;
                    state_next = ffpa_pkg::S_SHIFT_UP;
                end
            end
            ffpa_pkg::S_SHIFT_UP: begin
                if (stat.up_done) begin
                    state_next = ffpa_pkg::S_SPLIT;
                end else begin
                    cmd.shift_up = 1'b1;
                end
            end
            ffpa_pkg::S_SPLIT: begin
                cmd.split = 1'b1;
                cmd.set_result = 1'b1;
                cmd.result = ffpa_pkg::ST_OK;
                state_next = ffpa_pkg::S_RESULT;
            end
            ffpa_pkg::S_FREE: begin
                cmd.merge_free = 1'b1;
                cmd.set_result = 1'b1;
                cmd.result = ffpa_pkg::ST_OK;
                state_next = ffpa_pkg::S_SHIFT_DN;
            end
            ffpa_pkg::S_SHIFT_DN: begin
                if (stat.dn_done) begin
                    state_next = ffpa_pkg::S_RESULT;
                end else begin
                    cmd.shift_dn = 1'b1;
                end
            end
            ffpa_pkg::S_RESULT: begin
                if (!out_busy) begin
                    res_valid = 1'b1;
                    state_next = ffpa_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ffpa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ffpa_datapath.sv @@
// Datapath of the first-fit partition allocator: segment table, scan index,
// split and merge logic. Depends on ffpa_pkg.
module ffpa_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [15:0]                           cfg_wdata,
    input  logic                                  req_type,
    input  logic [ffpa_pkg::IdBits-1:0]           owner_id,
    input  logic [ffpa_pkg::AddrBits-1:0]         request_size,
    input  ffpa_pkg::ffpa_cmd_t                   cmd,
    output ffpa_pkg::ffpa_stat_t                  stat,
    output logic [2:0]                            res_status,
    output logic [ffpa_pkg::AddrBits-1:0]         res_addr
);

    localparam int N  = ffpa_pkg::MaxSegments;
    localparam int AB = ffpa_pkg::AddrBits;
    localparam int IB = ffpa_pkg::IdxBits;
    localparam int CB = ffpa_pkg::CntBits;

    logic [AB-1:0] start_reg  [N];
    logic [AB-1:0] length_reg [N];
    logic [N-1:0]  free_reg;
    logic [ffpa_pkg::IdBits-1:0] owner_reg [N];
    logic [CB-1:0] count_reg;

    logic                        type_reg;
    logic [ffpa_pkg::IdBits-1:0] id_reg;
    logic [AB-1:0]               size_reg;
    logic [CB-1:0]               idx_reg;   // scan position
    logic [IB-1:0]               hit_reg;   // found entry
    logic [CB-1:0]               mv_reg;    // copy position for shifts
    logic [CB-1:0]               dn_end_reg;
    logic [2:0]                  status_reg;
    logic [AB-1:0]               addr_reg;
    // Source of a downward copy lies one or two entries above.
    logic [1:0]                  gap_reg;

    logic [IB-1:0] idx;
    logic [IB-1:0] mv;
    logic [IB-1:0] mvm1;
    logic [IB-1:0] mv_src;
    logic [IB-1:0] hp1;
    logic [IB-1:0] hm1;
    logic          prev_free;
    logic          next_free;

    assign idx    = idx_reg[IB-1:0];
    assign mv     = mv_reg[IB-1:0];
    assign mvm1   = mv - IB'(1);
    assign mv_src = mv + IB'(gap_reg);
    assign hp1    = hit_reg + IB'(1);
    assign hm1    = hit_reg - IB'(1);
    assign prev_free = (hit_reg != '0) && free_reg[hm1];
    assign next_free = ({1'b0, hit_reg} + CB'(1) < count_reg) && free_reg[hp1];

    always_comb begin
        stat = '0;
        stat.is_free_req = type_reg;
        stat.scan_end   = (idx_reg >= count_reg);
        stat.owner_hit  = !free_reg[idx] && (owner_reg[idx] == id_reg);
        stat.fit_hit    = free_reg[idx] && (length_reg[idx] >= size_reg);
        stat.exact      = (length_reg[hit_reg] == size_reg);
        stat.size_zero  = (size_reg == '0);
        stat.table_full = (count_reg >= CB'(N));
        stat.up_done    = (mv_reg == {1'b0, hit_reg});
        stat.dn_done    = !(mv_reg < dn_end_reg);
    end

    assign res_status = status_reg;
    assign res_addr   = addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CB'(1);
            free_reg  <= {{(N-1){1'b0}}, 1'b1};
            start_reg[0]  <= '0;
            length_reg[0] <= AB'(ffpa_pkg::TotalSizeReset);
            mv_reg     <= '0;
            dn_end_reg <= '0;
            type_reg   <= 1'b0;
            id_reg     <= '0;
            size_reg   <= '0;
            idx_reg    <= '0;
            hit_reg    <= '0;
            status_reg <= '0;
            addr_reg   <= '0;
            gap_reg    <= 2'd1;
        end else if (cfg_we) begin
            count_reg <= CB'(1);
            free_reg  <= {{(N-1){1'b0}}, 1'b1};
            start_reg[0]  <= '0;
            length_reg[0] <= AB'(cfg_wdata);
        end else begin
            if (cmd.load_req) begin
                type_reg <= req_type;
                id_reg   <= owner_id;
                size_reg <= request_size;
            end
            if (cmd.scan_clr) begin
                idx_reg <= '0;
            end else if (cmd.scan_step) begin
                idx_reg <= idx_reg + CB'(1);
            end
            if (cmd.mark_hit) begin
                hit_reg <= idx;
            end
            // A successful result always comes with its own address write.
            if (cmd.set_result) begin
                status_reg <= cmd.result;
                if (cmd.result != ffpa_pkg::ST_OK) begin
                    addr_reg <= '0;
                end
            end
            if (cmd.take_whole) begin
                free_reg[hit_reg] <= 1'b0;
                owner_reg[hit_reg] <= id_reg;
                addr_reg <= start_reg[hit_reg];
            end
            if (cmd.open_gap) begin
                mv_reg <= count_reg;
            end
            if (cmd.shift_up) begin
                start_reg[mv]  <= start_reg[mvm1];
                length_reg[mv] <= length_reg[mvm1];
                free_reg[mv]   <= free_reg[mvm1];
                owner_reg[mv]  <= owner_reg[mvm1];
                mv_reg <= mv_reg - CB'(1);
            end
            if (cmd.split) begin
                count_reg <= count_reg + CB'(1);
                length_reg[hit_reg] <= size_reg;
                free_reg[hit_reg]   <= 1'b0;
                owner_reg[hit_reg]  <= id_reg;
                start_reg[hp1]  <= start_reg[hit_reg] + size_reg;
                length_reg[hp1] <= length_reg[hp1] - size_reg;
                addr_reg <= start_reg[hit_reg];
            end
            if (cmd.merge_free) begin
                addr_reg <= start_reg[hit_reg];
                if (prev_free && next_free) begin
                    length_reg[hm1] <= length_reg[hm1] + length_reg[hit_reg]
                                       + length_reg[hp1];
                    // Remove two entries: copy from hit+2 into hit.
                    mv_reg     <= {1'b0, hit_reg};
                    dn_end_reg <= count_reg - CB'(2);
                    count_reg  <= count_reg - CB'(2);
                end else if (prev_free) begin
                    length_reg[hm1] <= length_reg[hm1] + length_reg[hit_reg];
                    mv_reg     <= {1'b0, hit_reg};
                    dn_end_reg <= count_reg - CB'(1);
                    count_reg  <= count_reg - CB'(1);
                end else if (next_free) begin
                    length_reg[hit_reg] <= length_reg[hit_reg] + length_reg[hp1];
                    free_reg[hit_reg]   <= 1'b1;
                    mv_reg     <= {1'b0, hp1};
                    dn_end_reg <= count_reg - CB'(1);
                    count_reg  <= count_reg - CB'(1);
                end else begin
                    free_reg[hit_reg] <= 1'b1;
                    mv_reg     <= '0;
                    dn_end_reg <= '0;
                end
                gap_reg <= (prev_free && next_free) ? 2'd2 : 2'd1;
            end
            if (cmd.shift_dn) begin
                start_reg[mv]  <= start_reg[mv_src];
                length_reg[mv] <= length_reg[mv_src];
                free_reg[mv]   <= free_reg[mv_src];
                owner_reg[mv]  <= owner_reg[mv_src];
                mv_reg <= mv_reg + CB'(1);
            end
        end
    end

endmodule

@@ rtl/first_fit_partition_allocator.sv @@
// Top level of the first-fit partition allocator.
// Depends on ffpa_pkg, ffpa_ctrl and ffpa_datapath.
//
// The allocator keeps an address-ordered table of up to 16 segments over
// [0, total_size). Each request beat gives exactly one result beat, and a
// new request is taken only after the previous result beat has gone out.
// An item scans the table entry by entry for the owner, scans it again for
// the first fit on allocation, then moves entries one at a time, with a
// separate split or merge step. The next request can be taken in the cycle
// after the result beat is taken. Writing total_size reloads the table
// with one free segment; write it only while no request is in flight.
module first_fit_partition_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] owner_id, [23:8] request_size
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [2:0] status, [18:3] start_address, zero fill
);

    ffpa_pkg::ffpa_cmd_t  cmd;
    ffpa_pkg::ffpa_stat_t stat;
    logic        idle;
    logic        in_fire;
    logic        res_valid;
    logic [2:0]  res_status;
    logic [15:0] res_addr;
    logic        busy_reg;

    // The output register holds the result; a new beat is taken only once
    // the previous result has been taken.
    assign s_tready = idle && !busy_reg;
    assign in_fire  = s_tvalid && s_tready;

    ffpa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .out_busy  (busy_reg),
        .stat      (stat),
        .cmd       (cmd),
        .idle      (idle),
        .res_valid (res_valid)
    );

    ffpa_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .req_type     (s_tuser),
        .owner_id     (s_tdata[7:0]),
        .request_size (s_tdata[23:8]),
        .cmd          (cmd),
        .stat         (stat),
        .res_status   (res_status),
        .res_addr     (res_addr)
    );

    // The result is shown once the controller leaves its result state and
    // stays until the result beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (res_valid) begin
            busy_reg <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            busy_reg <= 1'b0;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = {5'd0, res_addr, res_status};

endmodule

@@ rtl/ffpa_checker.sv @@
// Port-level checker for the first-fit partition allocator, bound to the
// top level. Depends on nothing but the top level's ports.
module ffpa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_no_accept_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while result pending");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= 3'd4)) else $error("bad status");

    a_addr_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] != 3'd0) |-> (m_tdata[18:3] == 16'd0))
        else $error("address nonzero on error");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

bind first_fit_partition_allocator ffpa_checker u_ffpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/tb.sv @@
// Self-checking testbench for first_fit_partition_allocator.
// Depends on ffpa_pkg and the allocator RTL; it predicts every result beat
// from its own copy of the segment table and compares it field by field.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit          is_free;
        logic [7:0]  id;
        logic [15:0] size;
    } req_t;

    typedef struct {
        ffpa_pkg::status_t st;
        logic [15:0]       addr;
    } outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // Requests waiting to be offered and outcomes waiting for their beat.
    req_t     pending_reqs[$];
    outcome_t expected_outcomes[$];

    // The allocator's segment table as the testbench sees it.
    logic [15:0] seg_base[ffpa_pkg::MaxSegments];
    logic [15:0] seg_len[ffpa_pkg::MaxSegments];
    bit          seg_free[ffpa_pkg::MaxSegments];
    logic [7:0]  seg_own[ffpa_pkg::MaxSegments];
    int          seg_cnt;

    int  mismatches = 0;
    int  reqs_pushed = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    bit  calm = 1'b0;       // when set, neither side idles
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    req_t cur_req;

    always #5 aclk = ~aclk;

    first_fit_partition_allocator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Reloading the table leaves one free segment spanning the whole range.
    function automatic void reload_table(input logic [15:0] total);
        for (int k = 0; k < ffpa_pkg::MaxSegments; k++) begin
            seg_base[k] = '0;
            seg_len[k]  = '0;
            seg_free[k] = 1'b0;
            seg_own[k]  = '0;
        end
        seg_len[0]  = total;
        seg_free[0] = 1'b1;
        seg_cnt     = 1;
    endfunction

    function automatic void move_entry(input int dst, input int src);
        seg_base[dst] = seg_base[src];
        seg_len[dst]  = seg_len[src];
        seg_free[dst] = seg_free[src];
        seg_own[dst]  = seg_own[src];
    endfunction

    function automatic void drop_entry(input int idx);
        for (int k = idx; k + 1 < seg_cnt; k++) move_entry(k, k + 1);
        seg_cnt--;
    endfunction

    // Index of the segment owned by id, or seg_cnt when the id owns nothing.
    function automatic int owner_slot(input logic [7:0] id);
        for (int k = 0; k < seg_cnt; k++)
            if (!seg_free[k] && seg_own[k] == id) return k;
        return seg_cnt;
    endfunction

    // Applies one request to the table and returns the result it must give.
    function automatic outcome_t apply_request(input req_t r);
        outcome_t e;
        int       hit;
        int       k;
        bit       pf;
        bit       nf;
        e.st   = ffpa_pkg::ST_OK;
        e.addr = '0;
        hit    = owner_slot(r.id);
        if (!r.is_free) begin
            // The duplicate-id check comes ahead of every other allocate check.
            if (hit < seg_cnt) begin
                e.st = ffpa_pkg::ST_EXISTS;
            end else if (r.size == 0) begin
                e.st = ffpa_pkg::ST_NOFIT;
            end else begin
                k = 0;
                while (k < seg_cnt && !(seg_free[k] && seg_len[k] >= r.size)) k++;
                if (k >= seg_cnt) begin
                    e.st = ffpa_pkg::ST_NOFIT;
                end else if (seg_len[k] == r.size) begin
                    seg_free[k] = 1'b0;
                    seg_own[k]  = r.id;
                    e.addr      = seg_base[k];
                end else if (seg_cnt >= ffpa_pkg::MaxSegments) begin
                    e.st = ffpa_pkg::ST_FULL;
                end else begin
                    for (int j = seg_cnt; j > k; j--) move_entry(j, j - 1);
                    seg_cnt++;
                    seg_len[k]      = r.size;
                    seg_free[k]     = 1'b0;
                    seg_own[k]      = r.id;
                    seg_base[k + 1] = seg_base[k] + r.size;
                    seg_len[k + 1]  = seg_len[k + 1] - r.size;
                    e.addr          = seg_base[k];
                end
            end
        end else if (hit >= seg_cnt) begin
            e.st = ffpa_pkg::ST_NOTFOUND;
        end else begin
            e.addr = seg_base[hit];
            pf = (hit > 0) && seg_free[hit - 1];
            nf = (hit + 1 < seg_cnt) && seg_free[hit + 1];
            if (pf && nf) begin
                seg_len[hit - 1] = seg_len[hit - 1] + seg_len[hit] + seg_len[hit + 1];
                drop_entry(hit + 1);
                drop_entry(hit);
            end else if (pf) begin
                seg_len[hit - 1] = seg_len[hit - 1] + seg_len[hit];
                drop_entry(hit);
            end else if (nf) begin
                // Merging only forward must still mark the segment free.
                seg_len[hit]  = seg_len[hit] + seg_len[hit + 1];
                seg_free[hit] = 1'b1;
                drop_entry(hit + 1);
            end else begin
                seg_free[hit] = 1'b1;
            end
        end
        return e;
    endfunction

    // Driver: the expectation is computed at the edge where the beat is taken,
    // then the next request is offered unless this cycle idles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_outcomes = {expected_outcomes, apply_request(cur_req)};
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
                    cur_req  = pending_reqs.pop_front();
                    s_tdata  <= {cur_req.size, cur_req.id};
                    s_tuser  <= cur_req.is_free;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted in cycles, that lets the block back up.
    always @(posedge aclk) begin
        if (!hold_done && results_seen >= 400) begin
            hold_done <= 1'b1;
            hold_left <= 400;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks each result beat against the oldest expectation and
    // drives tready.
    always @(posedge aclk) begin
        outcome_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result beat with no request outstanding: tdata=%h", m_tdata);
                end else begin
                    e = expected_outcomes.pop_front();
                    if (m_tdata[2:0] !== e.st || m_tdata[18:3] !== e.addr) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch at beat %0d: status %0d/%0d, addr %h/%h (exp/act)",
                                     results_seen, e.st, m_tdata[2:0], e.addr, m_tdata[18:3]);
                    end
                end
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || $urandom_range(99) >= 33;
            end
        end
    end

    // Watchdog: too long without any beat on either side ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_req(input bit is_free, input logic [7:0] id, input logic [15:0] size);
        req_t r;
        r.is_free = is_free;
        r.id      = id;
        r.size    = size;
        pending_reqs = {pending_reqs, r};
        reqs_pushed++;
    endtask

    // Every request yields one beat, so the block is idle once all are back.
    task automatic drain();
        while (results_seen != reqs_pushed || pending_reqs.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // Register write while idle; the table model reloads at the same edge.
    task automatic write_total(input logic [15:0] total);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= total;
        @(posedge aclk);
        cfg_we <= 1'b0;
        reload_table(total);
    endtask

    // Random requests: mostly a small pool of ids with sizes scaled to the
    // range so tables fill, split and merge; some full-range noise.
    task automatic random_phase(input int n, input logic [15:0] total);
        logic [15:0] sz;
        logic [7:0]  id;
        int          div;
        for (int i = 0; i < n; i++) begin
            id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(19));
            div = $urandom_range(40, 2);
            case ($urandom_range(9))
                0:       sz = 16'($urandom);
                1:       sz = 16'($urandom_range(3));
                default: sz = 16'($urandom_range(total / div + 1, 1));
            endcase
            queue_req(1'($urandom_range(1)), id, sz);
        end
        drain();
    endtask

    initial begin
        logic [15:0] tot;
        reload_table(ffpa_pkg::TotalSizeReset);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed checks on the reset-sized range.
        queue_req(1'b0, 8'd0, 16'd0);        // zero size
        queue_req(1'b1, 8'd5, 16'hFFFF);     // free of an unknown id
        queue_req(1'b0, 8'd1, 16'd100);      // split
        queue_req(1'b0, 8'd1, 16'd50);       // duplicate id
        queue_req(1'b0, 8'd2, 16'd2000);     // nothing large enough
        queue_req(1'b0, 8'd2, 16'd100);
        queue_req(1'b0, 8'd3, 16'd100);
        queue_req(1'b1, 8'd2, 16'd0);        // no free neighbour
        queue_req(1'b1, 8'd1, 16'd0);        // merge with the next only
        queue_req(1'b0, 8'd4, 16'd200);      // exact fit
        queue_req(1'b1, 8'd3, 16'd0);
        queue_req(1'b1, 8'd4, 16'd0);
        for (int i = 0; i < 16; i++) queue_req(1'b0, 8'(10 + i), 16'd1); // last one: table full
        queue_req(1'b1, 8'd11, 16'd0);
        queue_req(1'b1, 8'd12, 16'd0);       // merge with the previous
        queue_req(1'b1, 8'd14, 16'd0);
        queue_req(1'b1, 8'd13, 16'd0);       // merge on both sides
        drain();

        // Largest range taken whole by the widest id and size.
        write_total(16'hFFFF);
        queue_req(1'b0, 8'hFF, 16'hFFFF);
        queue_req(1'b1, 8'hFF, 16'd0);
        drain();

        // A range of zero length refuses every allocation.
        write_total(16'd0);
        queue_req(1'b0, 8'd7, 16'd1);
        queue_req(1'b0, 8'hAA, 16'h5555);
        drain();

        write_total(16'd1);
        random_phase(150, 16'd1);

        write_total(16'd1024);
        random_phase(500, 16'd1024);

        calm = 1'b1;
        write_total(16'hFFFF);
        random_phase(250, 16'hFFFF);
        calm = 1'b0;

        for (int p = 0; p < 4; p++) begin
            tot = 16'($urandom_range(65535, 1));
            write_total(tot);
            random_phase(200, tot);
        end

        if (expected_outcomes.size() != 0) mismatches += expected_outcomes.size();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
